// ----- rtl/core/ssf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared codes for the shortest-seek-first scheduler.
// ----------------------------------------------------------------------------
package ssf_pkg;

	localparam logic FUNC_ADD      = 1'b0;
	localparam logic FUNC_DISPATCH = 1'b1;

	localparam logic [1:0] ST_ADDED      = 2'd0;
	localparam logic [1:0] ST_FULL       = 2'd1;
	localparam logic [1:0] ST_DISPATCHED = 2'd2;
	localparam logic [1:0] ST_EMPTY      = 2'd3;

endpackage

// ----- rtl/core/shortest_seek_first_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_seek_first_scheduler
// Pending disk request queue; dispatch returns the request closest to the head.
// ----------------------------------------------------------------------------
//  channel   signals                                   handshake
//  command   func, req_sector, req_tag                 start & !busy
//  result    status, out_sector, out_tag,              done, one cycle
//            pending_count
//
//  Add: scans valid bits from slot 0 for the first free one; a full
//  queue answers from idle without a scan.
//  Dispatch: one request memory read per slot through a two-stage
//  distance/compare pipe; an empty queue answers from idle without a
//  scan. done rises in the same cycle that busy falls.
//  Reset clears valid bits, head position and count; the memory is not
//  cleared. The receiver cannot stall; one item is in work at a time.
// ----------------------------------------------------------------------------
module shortest_seek_first_scheduler
	import ssf_pkg::*;
#(
	parameter int QUEUE_DEPTH = 32,
	parameter int SECTOR_BITS = 48,
	parameter int TAG_BITS    = 8,
	localparam int IDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   func,
	input  logic [SECTOR_BITS-1:0] req_sector,
	input  logic [TAG_BITS-1:0]    req_tag,
	output logic                   done,
	output logic [1:0]             status,
	output logic [SECTOR_BITS-1:0] out_sector,
	output logic [TAG_BITS-1:0]    out_tag,
	output logic [CNT_W-1:0]       pending_count
);

	localparam int ENT_W = SECTOR_BITS + TAG_BITS;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADD,
		S_DSP,
		S_FIN
	} state_t;

	state_t                 state_q;
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [SECTOR_BITS-1:0] head_q;
	logic [CNT_W-1:0]       count_q;
	logic [IDX_W:0]         scan_q;
	logic [SECTOR_BITS-1:0] sector_q;
	logic [TAG_BITS-1:0]    tag_q;

	logic                   go_s1;
	logic                   vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [ENT_W-1:0]       rd_data_s1;
	logic                   go_s2;
	logic                   vld_s2;
	logic [IDX_W-1:0]       idx_s2;
	logic [SECTOR_BITS-1:0] dist_s2;
	logic [SECTOR_BITS-1:0] sec_s2;
	logic [TAG_BITS-1:0]    tag_s2;

	logic                   found_q;
	logic [IDX_W-1:0]       best_idx_q;
	logic [SECTOR_BITS-1:0] best_dist_q;
	logic [SECTOR_BITS-1:0] best_sec_q;
	logic [TAG_BITS-1:0]    best_tag_q;

	logic [ENT_W-1:0]       mem [QUEUE_DEPTH];

	logic                   done_q;
	logic [1:0]             status_q;
	logic [SECTOR_BITS-1:0] out_sector_q;
	logic [TAG_BITS-1:0]    out_tag_q;

	logic [IDX_W-1:0]       scan_idx;
	logic                   scan_more;
	logic                   mem_we;
	logic [SECTOR_BITS-1:0] rd_sec_s1;
	logic                   take_s2;

	assign scan_idx  = scan_q[IDX_W-1:0];
	assign scan_more = scan_q < (IDX_W + 1)'(QUEUE_DEPTH);
	assign mem_we    = (state_q == S_ADD) && !valid_q[scan_idx];
	assign rd_sec_s1 = rd_data_s1[ENT_W-1:TAG_BITS];
	assign take_s2   = go_s2 && vld_s2 && (!found_q || (dist_s2 < best_dist_q));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[scan_idx] <= {sector_q, tag_q};
		end
		rd_data_s1 <= mem[scan_idx];
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			sector_q <= req_sector;
			tag_q    <= req_tag;
		end
		vld_s1  <= valid_q[scan_idx];
		idx_s1  <= scan_idx;
		vld_s2  <= vld_s1;
		idx_s2  <= idx_s1;
		sec_s2  <= rd_sec_s1;
		tag_s2  <= rd_data_s1[TAG_BITS-1:0];
		dist_s2 <= (rd_sec_s1 >= head_q) ? (rd_sec_s1 - head_q) : (head_q - rd_sec_s1);
		if (take_s2) begin
			best_idx_q  <= idx_s2;
			best_dist_q <= dist_s2;
			best_sec_q  <= sec_s2;
			best_tag_q  <= tag_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			head_q       <= '0;
			count_q      <= '0;
			scan_q       <= '0;
			go_s1        <= 1'b0;
			go_s2        <= 1'b0;
			found_q      <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= ST_ADDED;
			out_sector_q <= '0;
			out_tag_q    <= '0;
		end else begin
			done_q <= 1'b0;
			go_s1  <= 1'b0;
			go_s2  <= go_s1;
			if (take_s2) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						scan_q  <= '0;
						found_q <= 1'b0;
						if (func == FUNC_ADD) begin
							if (count_q == CNT_W'(QUEUE_DEPTH)) begin
								done_q       <= 1'b1;
								status_q     <= ST_FULL;
								out_sector_q <= '0;
								out_tag_q    <= '0;
							end else begin
								state_q <= S_ADD;
							end
						end else begin
							if (count_q == '0) begin
								done_q       <= 1'b1;
								status_q     <= ST_EMPTY;
								out_sector_q <= '0;
								out_tag_q    <= '0;
							end else begin
								state_q <= S_DSP;
							end
						end
					end
				end
				S_ADD: begin
					if (!valid_q[scan_idx]) begin
						valid_q[scan_idx] <= 1'b1;
						count_q           <= count_q + 1'b1;
						done_q            <= 1'b1;
						status_q          <= ST_ADDED;
						out_sector_q      <= '0;
						out_tag_q         <= '0;
						state_q           <= S_IDLE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_DSP: begin
					if (scan_more) begin
						go_s1  <= 1'b1;
						scan_q <= scan_q + 1'b1;
					end
					if (go_s2 && (idx_s2 == IDX_W'(QUEUE_DEPTH - 1))) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					valid_q[best_idx_q] <= 1'b0;
					count_q             <= count_q - 1'b1;
					head_q              <= best_sec_q;
					done_q              <= 1'b1;
					status_q            <= ST_DISPATCHED;
					out_sector_q        <= best_sec_q;
					out_tag_q           <= best_tag_q;
					state_q             <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign out_sector    = out_sector_q;
	assign out_tag       = out_tag_q;
	assign pending_count = count_q;

endmodule

// ----- bench/tb_shortest_seek_first_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shortest_seek_first_scheduler
// Self-checking bench for the shortest-seek-first request scheduler. A queue
// of commands (directed corner cases, then bursts that fill and empty the
// request slots with random sectors and tags) feeds a negedge driver. Each
// accepted command is run through a local scheduler model. Every done
// strobe is compared field by field against the oldest predicted answer.
// ----------------------------------------------------------------------------
module tb_shortest_seek_first_scheduler;
	import ssf_pkg::*;

	localparam int DEPTH = 32;
	localparam int SEC_W = 48;
	localparam int TAG_W = 8;
	localparam int CNT_W = 6;
	localparam logic [SEC_W-1:0] SEC_MAX = {SEC_W{1'b1}};

	typedef struct packed {
		logic             hold;
		logic             f;
		logic [SEC_W-1:0] sec;
		logic [TAG_W-1:0] tg;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       st;
		logic [SEC_W-1:0] sec;
		logic [TAG_W-1:0] tg;
		logic [CNT_W-1:0] cnt;
	} answer_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             func = FUNC_ADD;
	logic [SEC_W-1:0] req_sector = '0;
	logic [TAG_W-1:0] req_tag = '0;
	logic             busy;
	logic             done;
	logic [1:0]       status;
	logic [SEC_W-1:0] out_sector;
	logic [TAG_W-1:0] out_tag;
	logic [CNT_W-1:0] pending_count;

	cmd_t    cmd_q[$];
	answer_t answer_q[$];
	int      n_total = 0;
	int      n_issued = 0;
	int      n_accepted = 0;
	int      n_err = 0;

	// scheduler state as seen by the bench
	logic             slot_used[DEPTH];
	logic [SEC_W-1:0] slot_sec[DEPTH];
	logic [TAG_W-1:0] slot_tag[DEPTH];
	logic [SEC_W-1:0] head = '0;
	int               n_waiting = 0;

	shortest_seek_first_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.req_sector(req_sector),
		.req_tag(req_tag),
		.done(done),
		.status(status),
		.out_sector(out_sector),
		.out_tag(out_tag),
		.pending_count(pending_count)
	);

	always #5 clk = ~clk;

	task automatic serve_command(input logic f, input logic [SEC_W-1:0] s,
			input logic [TAG_W-1:0] t);
		answer_t          a;
		int               best;
		logic [SEC_W-1:0] best_d;
		logic [SEC_W-1:0] d;
		a = '{st: ST_FULL, default: '0};
		best = -1;
		best_d = '0;
		if (f == FUNC_ADD) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (!slot_used[i]) begin
					slot_used[i] = 1'b1;
					slot_sec[i] = s;
					slot_tag[i] = t;
					n_waiting++;
					a.st = ST_ADDED;
					break;
				end
			end
		end else begin
			a.st = ST_EMPTY;
			for (int i = 0; i < DEPTH; i++) begin
				if (slot_used[i]) begin
					d = (slot_sec[i] >= head) ? slot_sec[i] - head : head - slot_sec[i];
					if (best < 0 || d < best_d) begin
						best = i;
						best_d = d;
					end
				end
			end
			if (best >= 0) begin
				slot_used[best] = 1'b0;
				n_waiting--;
				head = slot_sec[best];
				a.st = ST_DISPATCHED;
				a.sec = slot_sec[best];
				a.tg = slot_tag[best];
			end
		end
		a.cnt = CNT_W'(n_waiting);
		answer_q.push_back(a);
	endtask

	task automatic queue_cmd(input logic f, input logic [SEC_W-1:0] s,
			input logic [TAG_W-1:0] t);
		cmd_q.push_back('{hold: 1'b0, f: f, sec: s, tg: t});
		n_total++;
	endtask

	task automatic queue_hold();
		cmd_q.push_back('{hold: 1'b1, f: FUNC_ADD, sec: '0, tg: '0});
	endtask

	function automatic logic [SEC_W-1:0] pick_sector();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		case ($urandom_range(3))
			0: return r[SEC_W-1:0];
			1: return SEC_W'($urandom_range(63));
			2: return SEC_MAX - SEC_W'($urandom_range(63));
			default: return r[SEC_W-1:0] >> $urandom_range(SEC_W - 1);
		endcase
	endfunction

	// driver: one item at a time, held until the block takes it
	always @(negedge clk) begin : drive
		int   idle_pct;
		logic go;
		cmd_t c;
		go = 1'b0;
		if (n_issued < n_total / 3)
			idle_pct = 6;
		else if (n_issued < 2 * n_total / 3)
			idle_pct = 83;
		else
			idle_pct = 0;
		if (arst_n && !(start && n_accepted != n_issued)) begin
			if (cmd_q.size() > 0) begin
				if (cmd_q[0].hold) begin
					if (answer_q.size() == 0)
						void'(cmd_q.pop_front());
				end else if ($urandom_range(99) >= idle_pct) begin
					c = cmd_q.pop_front();
					go = 1'b1;
					func <= c.f;
					req_sector <= c.sec;
					req_tag <= c.tg;
					n_issued++;
				end
			end
			start <= go;
		end
	end

	// monitor: check results, then predict for the item taken at this edge
	always @(posedge clk) begin : watch
		answer_t a;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (answer_q.size() == 0) begin
					$error("result with no item outstanding");
					n_err++;
				end else begin
					a = answer_q.pop_front();
					if (status !== a.st) begin
						$error("status: expected %0d, got %0d", a.st, status);
						n_err++;
					end
					if (out_sector !== a.sec) begin
						$error("out_sector: expected %0h, got %0h", a.sec, out_sector);
						n_err++;
					end
					if (out_tag !== a.tg) begin
						$error("out_tag: expected %0h, got %0h", a.tg, out_tag);
						n_err++;
					end
					if (pending_count !== a.cnt) begin
						$error("pending_count: expected %0d, got %0d", a.cnt, pending_count);
						n_err++;
					end
				end
			end
			if (start && busy === 1'b0) begin
				serve_command(func, req_sector, req_tag);
				n_accepted++;
			end
		end
	end

	initial begin : main
		int   occ;
		int   n_rand;
		int   mode;
		int   len;
		logic is_add;
		for (int i = 0; i < DEPTH; i++)
			slot_used[i] = 1'b0;

		// directed corners
		queue_cmd(FUNC_DISPATCH, SEC_MAX, 8'hFF);	// empty queue
		queue_cmd(FUNC_ADD, SEC_MAX, 8'hFF);
		queue_cmd(FUNC_ADD, '0, 8'h00);
		queue_cmd(FUNC_ADD, '0, 8'h5A);				// duplicate sector
		queue_cmd(FUNC_DISPATCH, '0, '0);			// tie, lower slot
		queue_cmd(FUNC_DISPATCH, '0, '0);
		queue_cmd(FUNC_DISPATCH, '0, '0);			// farthest possible seek
		queue_cmd(FUNC_ADD, '0, 8'h01);
		queue_cmd(FUNC_ADD, SEC_MAX - 1, 8'h02);
		queue_cmd(FUNC_DISPATCH, '0, '0);
		queue_cmd(FUNC_DISPATCH, '0, '0);
		queue_cmd(FUNC_ADD, 48'd1000, 8'h10);
		queue_cmd(FUNC_DISPATCH, '0, '0);
		queue_cmd(FUNC_ADD, 48'd1100, 8'h11);
		queue_cmd(FUNC_ADD, 48'd900, 8'h12);
		queue_cmd(FUNC_DISPATCH, '0, '0);			// equal distance both sides
		queue_cmd(FUNC_DISPATCH, '0, '0);
		queue_cmd(FUNC_DISPATCH, '0, '0);
		queue_cmd(FUNC_ADD, 48'hAAAA_AAAA_AAAA, 8'h55);
		queue_cmd(FUNC_ADD, 48'h5555_5555_5555, 8'hAA);
		queue_cmd(FUNC_DISPATCH, '0, '0);
		queue_cmd(FUNC_DISPATCH, '0, '0);
		queue_hold();

		// random bursts: fill past full, drain past empty, mixed traffic
		occ = 0;
		n_rand = 0;
		while (n_rand < 510) begin
			mode = (n_rand == 0) ? 0 : $urandom_range(2);
			case (mode)
				0: len = DEPTH - occ + $urandom_range(1, 3);
				1: len = occ + $urandom_range(1, 3);
				default: len = $urandom_range(10, 40);
			endcase
			for (int k = 0; k < len; k++) begin
				is_add = (mode == 0) || (mode == 2 && $urandom_range(99) < 55);
				if (is_add) begin
					queue_cmd(FUNC_ADD, pick_sector(), TAG_W'($urandom_range(255)));
					if (occ < DEPTH)
						occ++;
				end else begin
					queue_cmd(FUNC_DISPATCH, pick_sector(), TAG_W'($urandom_range(255)));
					if (occ > 0)
						occ--;
				end
			end
			n_rand += len;
			if ($urandom_range(5) == 0)
				queue_hold();
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_total || answer_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (n_err == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		#3_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
